[sv/lfsr8_byte_stream_stats_unit_defines.svh]
// Assertion macros for the LFSR byte stream statistics unit.
// Included by the checker; no other dependencies.
`ifndef LFSR8_BYTE_STREAM_STATS_UNIT_DEFINES_SVH
`define LFSR8_BYTE_STREAM_STATS_UNIT_DEFINES_SVH

// same-cycle implication
`define LFSR8BS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lfsr8bs assertion failed");

// next-cycle implication
`define LFSR8BS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lfsr8bs assertion failed");

`endif

[sv/lfsr8bs_pkg.sv]
// Shared types, constants and functions for the LFSR byte stream unit.
// No dependencies.
package lfsr8bs_pkg;

  localparam logic [7:0] STEP_LIMIT = 8'd255;
  localparam logic [2:0] BIT_LAST   = 3'd7;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_SUM  = 3'b100
  } state_t;

  typedef struct packed {
    logic [7:0] sr;
    logic [7:0] acc;
  } lfsr_st_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, v[k]};
    end
    return n;
  endfunction

endpackage

[sv/lfsr8bs_step.sv]
// One Fibonacci LFSR step: taps 7,5,2,1 into bit 0, bit 7 into the accumulator.
// Depends on lfsr8bs_pkg.
module lfsr8bs_step (
  input  lfsr8bs_pkg::lfsr_st_t cur,
  output lfsr8bs_pkg::lfsr_st_t nxt
);

  logic fb;

  assign fb      = cur.sr[7] ^ cur.sr[5] ^ cur.sr[2] ^ cur.sr[1];
  assign nxt.sr  = {cur.sr[6:0], fb};
  assign nxt.acc = {cur.acc[6:0], cur.sr[7]};

endmodule

[sv/lfsr8_byte_stream_stats_unit.sv]
// Top level of the LFSR byte stream statistics unit.
// Depends on lfsr8bs_pkg and lfsr8bs_step.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_seed_value
//   out      output     out_valid/out_stall item_kind, byte_value, last_item, counts
//
// Without stalls a seed passes through the accept cycle, one LFSR step per cycle through
// the single step unit, and the summary load.
// A step that completes a byte, and the summary load, wait while the output register
// holds a stalled beat.
// in_stall is high from the seed beat until the summary is loaded.
// Synchronous active-low reset returns the sequencer to idle with no beat pending.
module lfsr8_byte_stream_stats_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_seed_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_item_kind,
  output logic [7:0] out_byte_value,
  output logic       out_last_item,
  output logic [4:0] out_even_bytes,
  output logic [4:0] out_odd_bytes,
  output logic [7:0] out_one_bits,
  output logic [7:0] out_zero_bits,
  output logic [4:0] out_bytes_emitted,
  output logic [7:0] out_steps_taken
);

  lfsr8bs_pkg::state_t   state_r, state_nxt;
  lfsr8bs_pkg::lfsr_st_t st_r, st_nxt, st_step;
  logic [7:0] seed_r, seed_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] step_cnt_r, step_cnt_nxt;
  logic [4:0] even_r, even_nxt;
  logic [4:0] odd_r, odd_nxt;
  logic [7:0] ones_r, ones_nxt;
  logic [4:0] bytes_r, bytes_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [4:0] o_even_r, o_even_nxt;
  logic [4:0] o_odd_r, o_odd_nxt;
  logic [7:0] o_ones_r, o_ones_nxt;
  logic [7:0] o_zeros_r, o_zeros_nxt;
  logic [4:0] o_bytes_r, o_bytes_nxt;
  logic [7:0] o_steps_r, o_steps_nxt;

  logic slot_free;
  logic byte_done;

  lfsr8bs_step u_step (
    .cur (st_r),
    .nxt (st_step)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign byte_done = (bit_cnt_r == lfsr8bs_pkg::BIT_LAST);

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    seed_nxt      = seed_r;
    bit_cnt_nxt   = bit_cnt_r;
    step_cnt_nxt  = step_cnt_r;
    even_nxt      = even_r;
    odd_nxt       = odd_r;
    ones_nxt      = ones_r;
    bytes_nxt     = bytes_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    o_even_nxt    = o_even_r;
    o_odd_nxt     = o_odd_r;
    o_ones_nxt    = o_ones_r;
    o_zeros_nxt   = o_zeros_r;
    o_bytes_nxt   = o_bytes_r;
    o_steps_nxt   = o_steps_r;
    unique case (state_r)
      lfsr8bs_pkg::ST_IDLE: begin
        if (in_valid) begin
          seed_nxt     = in_seed_value;
          st_nxt.sr    = in_seed_value;
          st_nxt.acc   = 8'd0;
          bit_cnt_nxt  = 3'd0;
          step_cnt_nxt = 8'd0;
          even_nxt     = 5'd0;
          odd_nxt      = 5'd0;
          ones_nxt     = 8'd0;
          bytes_nxt    = 5'd0;
          state_nxt    = lfsr8bs_pkg::ST_STEP;
        end
      end
      lfsr8bs_pkg::ST_STEP: begin
        if (!byte_done || slot_free) begin
          st_nxt       = st_step;
          bit_cnt_nxt  = bit_cnt_r + 3'd1;
          step_cnt_nxt = step_cnt_r + 8'd1;
          if (byte_done) begin
            ones_nxt  = ones_r + {4'd0, lfsr8bs_pkg::popcount8(st_step.acc)};
            bytes_nxt = bytes_r + 5'd1;
            if (st_step.acc[0]) begin
              odd_nxt = odd_r + 5'd1;
            end else begin
              even_nxt = even_r + 5'd1;
            end
            out_valid_nxt = 1'b1;
            kind_nxt      = lfsr8bs_pkg::KIND_BYTE;
            byte_nxt      = st_step.acc;
            last_nxt      = 1'b0;
            o_even_nxt    = 5'd0;
            o_odd_nxt     = 5'd0;
            o_ones_nxt    = 8'd0;
            o_zeros_nxt   = 8'd0;
            o_bytes_nxt   = 5'd0;
            o_steps_nxt   = 8'd0;
          end
          if ((st_step.sr == seed_r) || (step_cnt_nxt == lfsr8bs_pkg::STEP_LIMIT)) begin
            state_nxt = lfsr8bs_pkg::ST_SUM;
          end
        end
      end
      lfsr8bs_pkg::ST_SUM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = lfsr8bs_pkg::KIND_SUM;
          byte_nxt      = 8'd0;
          last_nxt      = 1'b1;
          o_even_nxt    = even_r;
          o_odd_nxt     = odd_r;
          o_ones_nxt    = ones_r;
          o_zeros_nxt   = {bytes_r, 3'b000} - ones_r;
          o_bytes_nxt   = bytes_r;
          o_steps_nxt   = step_cnt_r;
          state_nxt     = lfsr8bs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfsr8bs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfsr8bs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      seed_r      <= 8'd0;
      bit_cnt_r   <= 3'd0;
      step_cnt_r  <= 8'd0;
      even_r      <= 5'd0;
      odd_r       <= 5'd0;
      ones_r      <= 8'd0;
      bytes_r     <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      seed_r      <= seed_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      step_cnt_r  <= step_cnt_nxt;
      even_r      <= even_nxt;
      odd_r       <= odd_nxt;
      ones_r      <= ones_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    o_even_r  <= o_even_nxt;
    o_odd_r   <= o_odd_nxt;
    o_ones_r  <= o_ones_nxt;
    o_zeros_r <= o_zeros_nxt;
    o_bytes_r <= o_bytes_nxt;
    o_steps_r <= o_steps_nxt;
  end

  assign in_stall          = (state_r != lfsr8bs_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_item_kind     = kind_r;
  assign out_byte_value    = byte_r;
  assign out_last_item     = last_r;
  assign out_even_bytes    = o_even_r;
  assign out_odd_bytes     = o_odd_r;
  assign out_one_bits      = o_ones_r;
  assign out_zero_bits     = o_zeros_r;
  assign out_bytes_emitted = o_bytes_r;
  assign out_steps_taken   = o_steps_r;

endmodule

[sv/lfsr8bs_checker.sv]
// Port-level checker for the LFSR byte stream unit, bound to the top level.
// Depends on lfsr8_byte_stream_stats_unit_defines.svh.
`include "lfsr8_byte_stream_stats_unit_defines.svh"

module lfsr8bs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_item_kind,
  input logic [7:0] out_byte_value,
  input logic       out_last_item,
  input logic [4:0] out_even_bytes,
  input logic [4:0] out_odd_bytes,
  input logic [7:0] out_one_bits,
  input logic [7:0] out_zero_bits,
  input logic [4:0] out_bytes_emitted,
  input logic [7:0] out_steps_taken
);

  logic [48:0] beat;
  logic        sum_beat;
  logic        byte_beat;
  logic        counts_zero;
  logic        pair_ok;
  logic        bits_ok;

  assign beat = {out_item_kind, out_byte_value, out_last_item, out_even_bytes,
                 out_odd_bytes, out_one_bits, out_zero_bits, out_bytes_emitted,
                 out_steps_taken};
  assign sum_beat  = out_valid && out_item_kind;
  assign byte_beat = out_valid && !out_item_kind;
  assign counts_zero = (out_even_bytes == 5'd0) && (out_odd_bytes == 5'd0) &&
                       (out_one_bits == 8'd0) && (out_zero_bits == 8'd0) &&
                       (out_bytes_emitted == 5'd0) && (out_steps_taken == 8'd0);
  assign pair_ok = ({1'b0, out_even_bytes} + {1'b0, out_odd_bytes}) ==
                   {1'b0, out_bytes_emitted};
  assign bits_ok = ((out_one_bits + out_zero_bits) == {out_bytes_emitted, 3'b000}) &&
                   (out_steps_taken != 8'd0) && (out_byte_value == 8'd0);

  `LFSR8BS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(beat))
  `LFSR8BS_ASSERT_IMP(a_last, clk, rst_n, out_valid, out_last_item == out_item_kind)
  `LFSR8BS_ASSERT_IMP(a_byte, clk, rst_n, byte_beat, counts_zero)
  `LFSR8BS_ASSERT_IMP(a_pair, clk, rst_n, sum_beat, pair_ok)
  `LFSR8BS_ASSERT_IMP(a_bits, clk, rst_n, sum_beat, bits_ok)

endmodule

bind lfsr8_byte_stream_stats_unit lfsr8bs_checker u_lfsr8bs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_item_kind     (out_item_kind),
  .out_byte_value    (out_byte_value),
  .out_last_item     (out_last_item),
  .out_even_bytes    (out_even_bytes),
  .out_odd_bytes     (out_odd_bytes),
  .out_one_bits      (out_one_bits),
  .out_zero_bits     (out_zero_bits),
  .out_bytes_emitted (out_bytes_emitted),
  .out_steps_taken   (out_steps_taken)
);
